// ===== sv/quadrature_position_pid_macros.svh =====
// ----------------------------------------------------------------------------
// quadrature_position_pid_macros
// assertion macros for the position controller
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_PID_MACROS_SVH
`define QUADRATURE_POSITION_PID_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QPP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/qpp_pkg.sv =====
// ----------------------------------------------------------------------------
// qpp_pkg
// types and constants of the quadrature position controller
// ----------------------------------------------------------------------------
`default_nettype none
package qpp_pkg;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [1:0] FUNC_EDGE_A = 2'd0;
    localparam logic [1:0] FUNC_EDGE_B = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_TARGET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP = 2'd3;

    localparam logic [15:0] PROP_RST  = 16'd100;
    localparam logic [15:0] INTEG_RST = 16'd10;
    localparam logic [15:0] DERIV_RST = 16'd1;
    localparam logic [15:0] RECIP_RST = 16'd303;
    localparam logic [9:0]  SCALE_NUM = 10'd653;

    typedef struct packed {
        logic [1:0]        func;
        logic              enc_a;
        logic              enc_b;
        logic [15:0]       elapsed_us;
        logic signed [7:0] target_rev;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         duty;
        logic               drive_forward;
        logic signed [31:0] position_count;
    } t_out_word;

    typedef struct packed {
        logic edge_step;
        logic set_target;
        logic load_err;
        logic load_int;
        logic div_start;
        logic load_sum;
        logic load_duty;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

// ===== sv/qpp_datapath.sv =====
// ----------------------------------------------------------------------------
// qpp_datapath
// count, error, integral, serial divider and output scaling
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrature_position_pid_macros.svh"
module qpp_datapath #(
    parameter int COUNT_WIDTH = qpp_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = qpp_pkg::FRAC_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  qpp_pkg::t_cmd         i_cmd,
    output qpp_pkg::t_sts         o_sts,
    input  qpp_pkg::t_in_word     i_word,
    input  wire  [15:0]           i_prop_gain,
    input  wire  [15:0]           i_integ_gain,
    input  wire  [15:0]           i_deriv_gain,
    input  wire  [15:0]           i_recip,
    output qpp_pkg::t_out_word    o_result
);
    localparam int PW = COUNT_WIDTH + 18;
    localparam int QW = 34;
    localparam logic signed [63:0] TERM_LIM = 64'sd1 <<< 60;
    localparam logic signed [63:0] MAG_LIM  = 64'sd256 <<< FRAC_BITS;

    logic signed [COUNT_WIDTH-1:0] r_count;
    logic signed [7:0]             r_target;
    logic signed [63:0]            r_integ;
    logic signed [31:0]            r_prev;
    logic signed [31:0]            r_err;
    logic [15:0]                   r_elapsed;
    logic [QW-1:0]                 r_quo;
    logic [QW-1:0]                 r_rem;
    logic [5:0]                    r_bit;
    logic                          r_busy;
    logic                          r_dneg;
    logic signed [65:0]            r_sum;
    qpp_pkg::t_out_word            r_result;

    logic                          up;
    logic signed [PW-1:0]          p16;
    logic signed [PW+1:0]          e16;
    logic signed [PW+9:0]          e_sc;
    logic signed [63:0]            e_c;
    logic signed [31:0]            err_n;
    logic signed [63:0]            prod;
    logic signed [64:0]            isum;
    logic signed [63:0]            integ_n;
    logic signed [32:0]            diff;
    logic [QW-1:0]                 rem_sh;
    logic signed [63:0]            dterm;
    logic signed [63:0]            gp, gi, gd;
    logic [65:0]                   mag;
    logic [75:0]                   x;

    function automatic logic signed [63:0] gained(input logic signed [63:0] a,
                                                 input logic [15:0] g);
        logic signed [80:0] pr;
        begin
            pr = a * $signed({1'b0, g});
            if (pr > 81'(TERM_LIM)) gained = TERM_LIM;
            else if (pr < -81'(TERM_LIM)) gained = -TERM_LIM;
            else gained = pr[63:0];
        end
    endfunction

    always_comb begin
        up = (i_word.func == qpp_pkg::FUNC_EDGE_A) ? (i_word.enc_a != i_word.enc_b)
                                                   : (i_word.enc_a == i_word.enc_b);
        p16 = PW'(r_count) * $signed({2'b0, i_recip});
        e16 = ((PW+2)'(r_target) <<< 16) - (PW+2)'(p16);
        if (FRAC_BITS >= 16) begin
            e_sc = (PW+10)'(e16) <<< (FRAC_BITS - 16);
        end else begin
            e_sc = (PW+10)'(e16 >>> (16 - FRAC_BITS));
        end
        if (e_sc > (PW+10)'(64'sh7fffffff)) e_c = 64'sh7fffffff;
        else if (e_sc < -(PW+10)'(64'sh80000000)) e_c = -64'sh80000000;
        else e_c = 64'(e_sc);
        err_n = e_c[31:0];
        prod = 64'(r_err) * $signed({48'b0, r_elapsed});
        isum = 65'(r_integ) + 65'(prod);
        if (isum[64] != isum[63]) integ_n = isum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        else integ_n = isum[63:0];
        diff = 33'(r_err) - 33'(r_prev);
        rem_sh = {r_rem[QW-2:0], r_quo[QW-1]};
        dterm = r_dneg ? -64'($signed({1'b0, r_quo})) : 64'($signed({1'b0, r_quo}));
        if (r_elapsed == 16'd0) dterm = '0;
        gp = gained(64'(r_err), i_prop_gain);
        gi = gained(r_integ, i_integ_gain);
        gd = gained(dterm, i_deriv_gain);
        mag = r_sum[65] ? 66'(-r_sum) : 66'(r_sum);
        x = (76'(mag) * 76'(qpp_pkg::SCALE_NUM)) + (76'd1 << (FRAC_BITS + 7));
        x = x >> (FRAC_BITS + 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '0;
            r_integ  <= '0;
            r_prev   <= '0;
            r_busy   <= 1'b0;
            r_bit    <= '0;
        end else begin
            if (i_cmd.edge_step) r_count <= up ? r_count + 1'b1 : r_count - 1'b1;
            if (i_cmd.set_target) r_target <= i_word.target_rev;
            if (i_cmd.load_err) begin
                r_err     <= err_n;
                r_elapsed <= i_word.elapsed_us;
            end
            if (i_cmd.load_int && r_elapsed != 16'd0) r_integ <= integ_n;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_bit  <= 6'(QW);
                r_dneg <= diff[32];
                r_quo  <= QW'(diff[32] ? -diff : diff);
                r_rem  <= '0;
            end else if (r_busy) begin
                if (rem_sh >= QW'(r_elapsed)) begin
                    r_rem <= rem_sh - QW'(r_elapsed);
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_bit <= r_bit - 1'b1;
                if (r_bit == 6'd1) r_busy <= 1'b0;
            end
            if (i_cmd.load_sum) begin
                r_sum  <= 66'(gp) + 66'(gi) + 66'(gd);
                r_prev <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_duty) begin
            r_result.duty <= (mag >= 66'(MAG_LIM) || x > 76'd255) ? 8'd255 : x[7:0];
            r_result.drive_forward  <= (r_err > 32'sd0);
            r_result.position_count <= 32'(r_count);
        end
    end

    assign o_sts.div_done = !r_busy && !i_cmd.div_start;
    assign o_result = r_result;

    `QPP_ASSERT_NXT(a_div_runs, i_clk, i_rst_n, i_cmd.div_start, r_busy)
    `QPP_ASSERT_IMP(a_div_bits, i_clk, i_rst_n, r_busy, r_bit != 6'd0)
    `QPP_ASSERT_IMP(a_no_sum_busy, i_clk, i_rst_n, i_cmd.load_sum, !r_busy)
endmodule
`default_nettype wire

// ===== sv/qpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// qpp_ctrl
// sequencer for accepted words and tick computation
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrature_position_pid_macros.svh"
module qpp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [1:0]          i_func,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output qpp_pkg::t_cmd       o_cmd,
    input  qpp_pkg::t_sts       i_sts
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INT  = 6'b000010,
        S_DIV  = 6'b000100,
        S_SUM  = 6'b001000,
        S_DUTY = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   acc;

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        acc = i_in_valid && !o_in_stall;
        o_cmd = '0;
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_func) inside
                        qpp_pkg::FUNC_EDGE_A, qpp_pkg::FUNC_EDGE_B: o_cmd.edge_step = 1'b1;
                        qpp_pkg::FUNC_TARGET: o_cmd.set_target = 1'b1;
                        qpp_pkg::FUNC_TICK: begin
                            o_cmd.load_err = 1'b1;
                            n_state = S_INT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INT: begin
                o_cmd.load_int  = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: if (i_sts.div_done) n_state = S_SUM;
            S_SUM: begin
                o_cmd.load_sum = 1'b1;
                n_state = S_DUTY;
            end
            S_DUTY: begin
                if (!r_out_valid) begin
                    o_cmd.load_duty = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `QPP_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `QPP_ASSERT_NXT(a_out_set, i_clk, i_rst_n, r_state == S_OUT, r_out_valid)
    `QPP_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
endmodule
`default_nettype wire

// ===== sv/quadrature_position_pid.sv =====
// ----------------------------------------------------------------------------
// quadrature_position_pid
// position pid loop driven by quadrature encoder edge words
// ----------------------------------------------------------------------------
// input words: edge on a, edge on b, control tick, set target. edge and target
// words give no output word. a tick word runs the error, integral, a 34-bit
// serial divide for the derivative, gain sum and duty scaling, then sets the
// output valid; no further word is taken until the tick is done, so tick
// throughput is bounded by the serial divider.
// input stall is high while a tick is being worked. a waiting output word
// holds until taken; a following tick then holds before its duty stage until
// the output register is free.
// config writes use i_cfg_valid / o_cfg_ready, ready always high; write only
// when idle. unknown indexes are ignored.
// synchronous active-low reset clears count, target, integral, previous error
// and restores the gain registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module quadrature_position_pid #(
    parameter int COUNT_WIDTH = qpp_pkg::COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = qpp_pkg::FRAC_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  qpp_pkg::t_in_word                i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output qpp_pkg::t_out_word               o_out_word,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [qpp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [15:0]                      i_cfg_data
);
    logic [15:0] r_prop, r_integ, r_deriv, r_recip;
    qpp_pkg::t_cmd cmd;
    qpp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop  <= qpp_pkg::PROP_RST;
            r_integ <= qpp_pkg::INTEG_RST;
            r_deriv <= qpp_pkg::DERIV_RST;
            r_recip <= qpp_pkg::RECIP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qpp_pkg::REG_PROP:  r_prop  <= i_cfg_data;
                qpp_pkg::REG_INTEG: r_integ <= i_cfg_data;
                qpp_pkg::REG_DERIV: r_deriv <= i_cfg_data;
                qpp_pkg::REG_RECIP: r_recip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    qpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_in_word.func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    qpp_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_word       (i_in_word),
        .i_prop_gain  (r_prop),
        .i_integ_gain (r_integ),
        .i_deriv_gain (r_deriv),
        .i_recip      (r_recip),
        .o_result     (o_out_word)
    );
endmodule
`default_nettype wire
